[hdl/ahfd_pkg.sv]
// Shared constants, types and helper functions for the ASCII hex frame decoder.
`default_nettype none

package ahfd_pkg;

   // CRC16-XMODEM: poly 0x1021, init 0x0000, MSB first
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_INIT = 16'h0000;

   // Frame layout
   localparam int DATA_START     = 5;
   localparam int TAIL_AFTER_SEP = 6;
   localparam int POS_W          = 9;
   localparam logic [POS_W-1:0] POS_MAX = '1;

   localparam logic [7:0] CHAR_SOF = 8'h3C;   // '<'
   localparam logic [7:0] CHAR_SEP = 8'h3A;   // ':'
   localparam logic [7:0] CHAR_EOF = 8'h3E;   // '>'

   // Register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   typedef enum logic {
      REG_CRC_CHECK_ON = 1'b0
   } csr_index_type;

   typedef enum logic {
      KIND_DATA   = 1'b0,
      KIND_STATUS = 1'b1
   } item_kind_type;

   typedef enum logic [1:0] {
      STAT_OK  = 2'd0,
      STAT_BAD = 2'd1,
      STAT_CRC = 2'd2
   } frame_status_type;

   typedef struct packed {
      logic       bad;
      logic [3:0] nibble;
   } hex_digit_type;

   // Decode one ASCII hex digit; a non-hex character is flagged and reads as 0.
   function automatic hex_digit_type hex_decode(input logic [7:0] c);
      hex_digit_type d;
      d.bad    = 1'b0;
      d.nibble = 4'h0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d.nibble = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d.nibble = 4'(c - 8'h37);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d.nibble = 4'(c - 8'h57);
      end else begin
         d.bad = 1'b1;
      end
      return d;
   endfunction

   // One byte of CRC16-XMODEM, unrolled over the eight bits.
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

[hdl/ascii_hex_frame_decoder_crc16.sv]
// Top level of the ASCII hex frame decoder with CRC16-XMODEM check.
`default_nettype none

// Decodes frames of the form '<' cmd DD ':' data-hex ':' [CCCC] '>' arriving one
// byte per req beat, with req_tlast on the last byte of the buffer. On every
// accepted byte the frame state (position, running CRC, counts, flags) is
// updated by a single pass of logic and the result, if any, lands in the rsp
// output register, so a byte can be accepted every cycle as long as the rsp side
// keeps draining. Each data byte goes out as a tentative data beat once its
// second hex digit arrives; the last byte of the buffer always yields a status
// beat (ok, bad frame or CRC mismatch) and restarts the decoder for a new frame.
// crc_check_on at byte address 0 selects whether four CRC digits precede '>'.
module ascii_hex_frame_decoder_crc16 (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   input  wire logic [7:0]                         req_tdata,   // [7:0] rx_byte
   input  wire logic                               req_tlast,   // end_of_buffer
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [7:0] data_byte, [15:8] command_char, [17:16] frame_status, [24:18] byte_count
   output      logic [31:0]                        rsp_tdata,
   output      logic                               rsp_tuser,   // item_kind
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [ahfd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [ahfd_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output      logic [ahfd_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output      logic                               csr_pready
);
   import ahfd_pkg::*;

   // Configuration
   logic             crc_on_ff;
   logic             csr_hit;
   logic             csr_wr;

   // Frame state
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       dcc_ff, dcc_in;
   logic [7:0]       cmd_ff, cmd_in;
   logic [15:0]      rcrc_ff, rcrc_in;
   logic [3:0]       nib_ff, nib_in;
   logic             sbad_ff, sbad_in;
   logic             dbad_ff, dbad_in;

   // Result register
   logic             rsp_valid_ff;
   logic             rsp_kind_ff, rsp_kind_in;
   logic [7:0]       rsp_data_ff, rsp_data_in;
   logic [7:0]       rsp_cmd_ff, rsp_cmd_in;
   logic [1:0]       rsp_stat_ff, rsp_stat_in;
   logic [6:0]       rsp_cnt_ff, rsp_cnt_in;
   logic             emit;

   logic             accept;
   logic [7:0]       b;
   logic             eob;
   logic [POS_W:0]   p;
   logic [POS_W:0]   sep2;
   logic [POS_W:0]   endpos;
   hex_digit_type    hx;
   logic [POS_W-1:0] data_idx;
   logic             sbad_fin;
   logic             dbad_fin;
   frame_status_type status;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_index_type'(csr_paddr[2]) == REG_CRC_CHECK_ON);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_hit ? {{(CSR_DATA_W-1){1'b0}}, crc_on_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_on_ff <= 1'b1;
      end else if (csr_wr && csr_hit) begin
         crc_on_ff <= csr_pwdata[0];
      end
   end

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign b          = req_tdata;
   assign eob        = req_tlast;
   assign p          = {1'b0, pos_ff};
   assign sep2       = (POS_W+1)'(DATA_START) + {2'b00, dcc_ff};
   assign endpos     = crc_on_ff ? sep2 + (POS_W+1)'(TAIL_AFTER_SEP - 1)
                                 : sep2 + (POS_W+1)'(1);
   assign hx         = hex_decode(b);
   assign data_idx   = pos_ff - POS_W'(DATA_START - 1);

   always_comb begin
      pos_in      = pos_ff;
      crc_in      = crc_ff;
      dcc_in      = dcc_ff;
      cmd_in      = cmd_ff;
      rcrc_in     = rcrc_ff;
      nib_in      = nib_ff;
      sbad_in     = sbad_ff;
      dbad_in     = dbad_ff;
      emit        = 1'b0;
      rsp_kind_in = KIND_DATA;
      rsp_data_in = 8'h00;
      rsp_stat_in = STAT_OK;
      rsp_cnt_in  = 7'd0;
      sbad_fin    = 1'b0;
      dbad_fin    = 1'b0;
      status      = STAT_OK;

      priority if (p == (POS_W+1)'(0)) begin
         if (b != CHAR_SOF) sbad_in = 1'b1;
      end else if (p == (POS_W+1)'(1)) begin
         cmd_in = b;
      end else if (p == (POS_W+1)'(2)) begin
         if (hx.bad) sbad_in = 1'b1;
         dcc_in = {hx.nibble, 4'h0};
      end else if (p == (POS_W+1)'(3)) begin
         if (hx.bad) sbad_in = 1'b1;
         dcc_in = {dcc_ff[7:4], hx.nibble};
      end else if (p == (POS_W+1)'(4)) begin
         if (b != CHAR_SEP) sbad_in = 1'b1;
      end else if (p < sep2) begin
         if (hx.bad) dbad_in = 1'b1;
         if (pos_ff[0]) begin
            // high nibble sits at odd positions
            nib_in = hx.nibble;
         end else begin
            nib_in      = 4'h0;
            emit        = !eob;
            rsp_data_in = {nib_ff, hx.nibble};
            rsp_cnt_in  = data_idx[7:1];
         end
      end else if (p == sep2) begin
         if (b != CHAR_SEP) sbad_in = 1'b1;
      end else if (crc_on_ff && p <= sep2 + (POS_W+1)'(4)) begin
         if (hx.bad) sbad_in = 1'b1;
         rcrc_in = {rcrc_ff[11:0], hx.nibble};
      end else begin
         // trailing bytes only advance the position
      end

      if (p <= sep2) crc_in = crc16_byte(crc_ff, b);
      pos_in = (pos_ff == POS_MAX) ? POS_MAX : pos_ff + POS_W'(1);

      if (eob) begin
         sbad_fin = sbad_in || (p != endpos) || (b != CHAR_EOF);
         dbad_fin = dbad_in || dcc_in[0];
         priority if (sbad_fin) begin
            status = STAT_BAD;
         end else if (crc_on_ff && crc_in != rcrc_in) begin
            status = STAT_CRC;
         end else if (dbad_fin) begin
            status = STAT_BAD;
         end else begin
            status = STAT_OK;
         end
         emit        = 1'b1;
         rsp_kind_in = KIND_STATUS;
         rsp_data_in = 8'h00;
         rsp_stat_in = status;
         rsp_cnt_in  = (status == STAT_OK) ? dcc_in[7:1] : 7'd0;
         // restart for the next frame
         pos_in  = '0;
         crc_in  = CRC_INIT;
         dcc_in  = 8'h00;
         rcrc_in = 16'h0000;
         nib_in  = 4'h0;
         sbad_in = 1'b0;
         dbad_in = 1'b0;
      end
      rsp_cmd_in = cmd_in;
      if (eob) cmd_in = 8'h00;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         crc_ff  <= CRC_INIT;
         dcc_ff  <= 8'h00;
         cmd_ff  <= 8'h00;
         rcrc_ff <= 16'h0000;
         nib_ff  <= 4'h0;
         sbad_ff <= 1'b0;
         dbad_ff <= 1'b0;
      end else if (accept) begin
         pos_ff  <= pos_in;
         crc_ff  <= crc_in;
         dcc_ff  <= dcc_in;
         cmd_ff  <= cmd_in;
         rcrc_ff <= rcrc_in;
         nib_ff  <= nib_in;
         sbad_ff <= sbad_in;
         dbad_ff <= dbad_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= emit;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Load the result register only with a new beat
   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_data_ff <= rsp_data_in;
         rsp_cmd_ff  <= rsp_cmd_in;
         rsp_stat_ff <= rsp_stat_in;
         rsp_cnt_ff  <= rsp_cnt_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {7'h00, rsp_cnt_ff, rsp_stat_ff, rsp_cmd_ff, rsp_data_ff};

endmodule

`default_nettype wire

[hdl/ahfd_checker.sv]
// Port-level checker for the ASCII hex frame decoder, bound to the top level.
`default_nettype none

module ahfd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic        rsp_tuser
);
   import ahfd_pkg::*;

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp beat changed while stalled");

   a_data_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_DATA |->
         rsp_tdata[17:16] == STAT_OK && rsp_tdata[24:18] != 7'd0)
      else $error("data beat with status or zero index");

   a_status_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_STATUS |->
         rsp_tdata[7:0] == 8'h00 &&
         (rsp_tdata[17:16] == STAT_OK || rsp_tdata[17:16] == STAT_BAD ||
          rsp_tdata[17:16] == STAT_CRC))
      else $error("malformed status beat");

   a_fail_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_STATUS && rsp_tdata[17:16] != STAT_OK |->
         rsp_tdata[24:18] == 7'd0)
      else $error("failed frame reports a byte count");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

endmodule

bind ascii_hex_frame_decoder_crc16 ahfd_checker u_ahfd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
